@@ rtl/spdt_pkg.sv @@
// ============================================================================
// spdt_pkg
// Shared types and constants for the strict-priority task dispatcher.
// ============================================================================
package spdt_pkg;

    localparam int TAG_W  = 8;
    localparam int PRIO_W = 4;
    localparam int WC_W   = 8;
    localparam int PEND_W = 16;
    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    // register index taken from paddr[2]
    localparam logic REG_WORKER_COUNT = 1'b0;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_SCHED = 2'd1,
        CMD_FETCH = 2'd2,
        CMD_DONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ROUTE_NONE   = 2'd0,
        ROUTE_LOCAL  = 2'd1,
        ROUTE_WORKER = 2'd2
    } t_route;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic             found;
        logic [TAG_W-1:0] tag;
        t_route           route;
        t_status          status;
        logic             busy;
    } t_result;

endpackage

@@ rtl/spdt_ram.sv @@
// ============================================================================
// spdt_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ============================================================================
module spdt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/spdt_ctrl.sv @@
// ============================================================================
// spdt_ctrl
// Command sequencer: queue pointers, pending count, RAM access and result reg.
// ============================================================================
module spdt_ctrl
    import spdt_pkg::*;
#(
    parameter int NUM_PRIO     = 4,
    parameter int QUEUE_DEPTH  = 16,
    parameter int WORKER_DEPTH = 16,
    localparam int LV_W = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1,
    localparam int QP_W = $clog2(QUEUE_DEPTH),
    localparam int QF_W = $clog2(QUEUE_DEPTH + 1),
    localparam int WP_W = $clog2(WORKER_DEPTH),
    localparam int WF_W = $clog2(WORKER_DEPTH + 1),
    localparam int PA_W = $clog2(NUM_PRIO * QUEUE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_cmd,
    input  logic [TAG_W-1:0]  i_task_tag,
    input  logic [PRIO_W-1:0] i_priority_req,
    input  logic              i_heavy,
    output logic              o_valid,
    input  logic              i_ready,
    output t_result           o_res,
    input  logic [WC_W-1:0]   i_worker_count,
    output logic              o_pm_we,
    output logic [PA_W-1:0]   o_pm_waddr,
    output logic [TAG_W:0]    o_pm_wdata,
    output logic              o_pm_re,
    output logic [PA_W-1:0]   o_pm_raddr,
    input  logic [TAG_W:0]    i_pm_rdata,
    output logic              o_wm_we,
    output logic [WP_W-1:0]   o_wm_waddr,
    output logic [TAG_W-1:0]  o_wm_wdata,
    output logic              o_wm_re,
    output logic [WP_W-1:0]   o_wm_raddr,
    input  logic [TAG_W-1:0]  i_wm_rdata
);

    t_state r_state, n_state;

    logic [QP_W-1:0] r_head [NUM_PRIO];
    logic [QP_W-1:0] r_tail [NUM_PRIO];
    logic [QF_W-1:0] r_qfill [NUM_PRIO];
    logic [WP_W-1:0] r_whead, r_wtail, n_whead, n_wtail;
    logic [WF_W-1:0] r_wfill, n_wfill;
    logic [PEND_W-1:0] r_pend, n_pend;

    // transaction latched at accept
    t_cmd              r_cmd;
    logic [TAG_W-1:0]  r_tag;
    logic              r_heavy;
    logic [LV_W-1:0]   r_lvl;
    logic [QP_W-1:0]   r_ptr;
    logic [QF_W-1:0]   r_fill;
    logic [PA_W-1:0]   r_addr;
    logic              r_hit;

    logic    r_out_valid;
    t_result r_res, n_res;

    logic            in_acc, commit;
    t_cmd            cmd_in;
    logic            any_ne;
    logic [LV_W-1:0] enc_lvl, clamp_lvl, sel_lvl;
    logic [QP_W-1:0] sel_ptr;
    logic [QF_W-1:0] sel_fill;
    logic [PA_W-1:0] sel_addr;
    logic            sel_hit;
    logic            q_upd_tail, q_upd_head, w_push, w_pop;
    logic [QP_W-1:0] n_qptr;
    logic [QF_W-1:0] n_qfill;

    assign cmd_in = t_cmd'(i_cmd);
    assign in_acc = i_valid && o_ready;

    // ---------------- accept side: select level and issue RAM read ----------
    always_comb begin
        any_ne  = 1'b0;
        enc_lvl = '0;
        for (int i = NUM_PRIO - 1; i >= 0; i--) begin
            if (r_qfill[i] != '0) begin
                any_ne  = 1'b1;
                enc_lvl = LV_W'(i);
            end
        end
    end

    always_comb begin
        if (int'(i_priority_req) > NUM_PRIO - 1) begin
            clamp_lvl = LV_W'(NUM_PRIO - 1);
        end else begin
            clamp_lvl = LV_W'(i_priority_req);
        end
        sel_lvl  = (cmd_in == CMD_ADD) ? clamp_lvl : enc_lvl;
        sel_ptr  = (cmd_in == CMD_ADD) ? r_tail[sel_lvl] : r_head[sel_lvl];
        sel_fill = r_qfill[sel_lvl];
        sel_addr = PA_W'(int'(sel_lvl) * QUEUE_DEPTH + int'(sel_ptr));
        sel_hit  = (cmd_in == CMD_ADD) ? (sel_fill != QF_W'(QUEUE_DEPTH)) : any_ne;
    end

    assign o_pm_re    = in_acc && (cmd_in == CMD_SCHED) && any_ne;
    assign o_pm_raddr = sel_addr;
    assign o_wm_re    = in_acc && (cmd_in == CMD_FETCH);
    assign o_wm_raddr = r_whead;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        commit  = 1'b0;
        case (r_state)
            S_IDLE:  o_ready = 1'b1;
            S_EXEC:  commit  = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    // ---------------- execute: read-modify-write ----------------
    assign n_qptr = (r_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_ptr + QP_W'(1);

    always_comb begin
        n_res      = '0;
        n_res.route  = ROUTE_NONE;
        n_res.status = ST_OK;
        n_pend     = r_pend;
        n_qfill    = r_fill;
        q_upd_tail = 1'b0;
        q_upd_head = 1'b0;
        w_push     = 1'b0;
        w_pop      = 1'b0;
        case (r_cmd)
            CMD_ADD: begin
                if (!r_hit) begin
                    n_res.status = ST_FULL;
                end else begin
                    q_upd_tail = 1'b1;
                    n_qfill    = r_fill + QF_W'(1);
                    if (r_pend == PEND_MAX) begin
                        n_res.status = ST_SAT;
                    end else begin
                        n_pend = r_pend + PEND_W'(1);
                    end
                end
            end
            CMD_SCHED: begin
                if (!r_hit) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    q_upd_head  = 1'b1;
                    n_qfill     = r_fill - QF_W'(1);
                    n_res.found = 1'b1;
                    n_res.tag   = i_pm_rdata[TAG_W-1:0];
                    if (!i_pm_rdata[TAG_W] || (i_worker_count == '0)) begin
                        n_res.route = ROUTE_LOCAL;
                    end else if (r_wfill == WF_W'(WORKER_DEPTH)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        w_push      = 1'b1;
                        n_res.route = ROUTE_WORKER;
                    end
                end
            end
            CMD_FETCH: begin
                if (r_wfill == '0) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    w_pop       = 1'b1;
                    n_res.found = 1'b1;
                    n_res.tag   = i_wm_rdata;
                end
            end
            CMD_DONE: begin
                if (r_pend == '0) begin
                    n_res.status = ST_SAT;
                end else begin
                    n_pend = r_pend - PEND_W'(1);
                end
            end
            default: ;
        endcase
        n_res.busy = (n_pend != '0);
    end

    always_comb begin
        n_whead = r_whead;
        n_wtail = r_wtail;
        n_wfill = r_wfill;
        if (w_push) begin
            n_wtail = (r_wtail == WP_W'(WORKER_DEPTH - 1)) ? '0 : r_wtail + WP_W'(1);
            n_wfill = r_wfill + WF_W'(1);
        end
        if (w_pop) begin
            n_whead = (r_whead == WP_W'(WORKER_DEPTH - 1)) ? '0 : r_whead + WP_W'(1);
            n_wfill = r_wfill - WF_W'(1);
        end
    end

    assign o_pm_we    = commit && q_upd_tail;
    assign o_pm_waddr = r_addr;
    assign o_pm_wdata = {r_heavy, r_tag};
    assign o_wm_we    = commit && w_push;
    assign o_wm_waddr = r_wtail;
    assign o_wm_wdata = i_pm_rdata[TAG_W-1:0];

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_whead     <= '0;
            r_wtail     <= '0;
            r_wfill     <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_PRIO; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_qfill[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_whead     <= n_whead;
                r_wtail     <= n_wtail;
                r_wfill     <= n_wfill;
                r_pend      <= n_pend;
                r_out_valid <= 1'b1;
                if (q_upd_tail) begin
                    r_tail[r_lvl]  <= n_qptr;
                    r_qfill[r_lvl] <= n_qfill;
                end
                if (q_upd_head) begin
                    r_head[r_lvl]  <= n_qptr;
                    r_qfill[r_lvl] <= n_qfill;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= cmd_in;
            r_tag   <= i_task_tag;
            r_heavy <= i_heavy;
            r_lvl   <= sel_lvl;
            r_ptr   <= sel_ptr;
            r_fill  <= sel_fill;
            r_addr  <= sel_addr;
            r_hit   <= sel_hit;
        end
        if (commit) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    // ---------------- assertions ----------------
    a_wfill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wfill <= WF_W'(WORKER_DEPTH))
        else $error("worker fill above depth");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result without execute cycle");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && w_push) |=> (r_wfill == $past(r_wfill) + WF_W'(1)))
        else $error("worker push not counted");

    a_busy_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.busy == (r_pend != '0)))
        else $error("busy flag out of step with pending count");

    a_route_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.route != ROUTE_NONE)) |-> r_res.found)
        else $error("dispatch without a tag");

endmodule

@@ rtl/strict_priority_task_dispatcher.sv @@
// ============================================================================
// strict_priority_task_dispatcher
// Per-priority tag FIFOs plus a worker FIFO, held in synchronous RAMs.
// ============================================================================
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+---------------------------------
//  command   | in        | i_valid / o_ready  | i_cmd i_task_tag i_priority_req
//            |           |                    | i_heavy
//  result    | out       | o_valid / i_ready  | o_found o_out_tag o_route
//            |           |                    | o_status o_busy_res
//  config    | in        | psel/penable/pready| paddr pwdata pwrite -> prdata
//
//  The accept in S_IDLE issues the RAM read (queue head or worker head) and
//  S_EXEC, using the registered RAM read data, writes back pointers, RAM and
//  the result register. A new transaction is taken while the previous
//  result waits in the output register; execution holds if that register
//  is still occupied.
//  Reset is synchronous, active low, and clears pointers, fill counts,
//  the pending count and worker_count; the RAMs need no clearing pass.
//
module strict_priority_task_dispatcher
    import spdt_pkg::*;
#(
    parameter int NUM_PRIO     = 4,
    parameter int QUEUE_DEPTH  = 16,
    parameter int WORKER_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command transaction
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_cmd,
    input  logic [TAG_W-1:0]  i_task_tag,
    input  logic [PRIO_W-1:0] i_priority_req,
    input  logic              i_heavy,
    // result transaction
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_found,
    output logic [TAG_W-1:0]  o_out_tag,
    output logic [1:0]        o_route,
    output logic [1:0]        o_status,
    output logic              o_busy_res,
    // APB-style register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int WP_W = $clog2(WORKER_DEPTH);
    localparam int PA_W = $clog2(NUM_PRIO * QUEUE_DEPTH);

    // worker_count register; paddr[2] selects the register word
    logic [WC_W-1:0] r_worker_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_worker_count <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_WORKER_COUNT)) begin
            r_worker_count <= pwdata[WC_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WORKER_COUNT) ? {{(32 - WC_W){1'b0}}, r_worker_count}
                                                    : '0;

    // RAM connections
    logic              pm_we, pm_re;
    logic [PA_W-1:0]   pm_waddr, pm_raddr;
    logic [TAG_W:0]    pm_wdata, pm_rdata;
    logic              wm_we, wm_re;
    logic [WP_W-1:0]   wm_waddr, wm_raddr;
    logic [TAG_W-1:0]  wm_wdata, wm_rdata;
    t_result           res;

    // {heavy, tag} entries, one region of QUEUE_DEPTH per level
    spdt_ram #(
        .WIDTH (TAG_W + 1),
        .DEPTH (NUM_PRIO * QUEUE_DEPTH),
        .AW    (PA_W)
    ) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (pm_wdata),
        .i_re    (pm_re),
        .i_raddr (pm_raddr),
        .o_rdata (pm_rdata)
    );

    // tags handed to workers
    spdt_ram #(
        .WIDTH (TAG_W),
        .DEPTH (WORKER_DEPTH),
        .AW    (WP_W)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (wm_we),
        .i_waddr (wm_waddr),
        .i_wdata (wm_wdata),
        .i_re    (wm_re),
        .i_raddr (wm_raddr),
        .o_rdata (wm_rdata)
    );

    spdt_ctrl #(
        .NUM_PRIO     (NUM_PRIO),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .WORKER_DEPTH (WORKER_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_task_tag     (i_task_tag),
        .i_priority_req (i_priority_req),
        .i_heavy        (i_heavy),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_res          (res),
        .i_worker_count (r_worker_count),
        .o_pm_we        (pm_we),
        .o_pm_waddr     (pm_waddr),
        .o_pm_wdata     (pm_wdata),
        .o_pm_re        (pm_re),
        .o_pm_raddr     (pm_raddr),
        .i_pm_rdata     (pm_rdata),
        .o_wm_we        (wm_we),
        .o_wm_waddr     (wm_waddr),
        .o_wm_wdata     (wm_wdata),
        .o_wm_re        (wm_re),
        .o_wm_raddr     (wm_raddr),
        .i_wm_rdata     (wm_rdata)
    );

    // result fields
    assign o_found    = res.found;
    assign o_out_tag  = res.tag;
    assign o_route    = res.route;
    assign o_status   = res.status;
    assign o_busy_res = res.busy;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for strict_priority_task_dispatcher.
// Commands go in over a valid/ready channel. A shadow model of the priority
// queues, the worker queue and the pending counter predicts every result
// transaction, and each result is checked field by field in order. The run
// covers directed corner cases, random command mixes under several worker
// counts, a long result-side hold-off, and the pending counter stepped up
// and back down.
// ============================================================================
module testbench;
    import spdt_pkg::*;

    localparam int NUM_PRIO     = 4;
    localparam int QUEUE_DEPTH  = 16;
    localparam int WORKER_DEPTH = 16;
    localparam logic [2:0] ADDR_WORKER_COUNT = {REG_WORKER_COUNT, 2'b00};

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              o_ready;
    logic [1:0]        i_cmd          = CMD_ADD;
    logic [TAG_W-1:0]  i_task_tag     = '0;
    logic [PRIO_W-1:0] i_priority_req = '0;
    logic              i_heavy        = 1'b0;
    logic              o_valid;
    logic              i_ready        = 1'b0;
    logic              o_found;
    logic [TAG_W-1:0]  o_out_tag;
    logic [1:0]        o_route;
    logic [1:0]        o_status;
    logic              o_busy_res;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [2:0]        paddr          = '0;
    logic [31:0]       pwdata         = '0;
    logic [31:0]       prdata;
    logic              pready;

    strict_priority_task_dispatcher #(
        .NUM_PRIO     (NUM_PRIO),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .WORKER_DEPTH (WORKER_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_task_tag     (i_task_tag),
        .i_priority_req (i_priority_req),
        .i_heavy        (i_heavy),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found        (o_found),
        .o_out_tag      (o_out_tag),
        .o_route        (o_route),
        .o_status       (o_status),
        .o_busy_res     (o_busy_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run (about 2000 transactions
    // under random stalls and gaps).
    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow state of the dispatcher
    // ------------------------------------------------------------------------
    logic [8:0]        shadow_prio_mem  [NUM_PRIO][QUEUE_DEPTH];   // {heavy, tag}
    int unsigned       shadow_prio_head [NUM_PRIO];
    int unsigned       shadow_prio_tail [NUM_PRIO];
    int unsigned       shadow_prio_fill [NUM_PRIO];
    logic [TAG_W-1:0]  shadow_wk_mem    [WORKER_DEPTH];
    int unsigned       shadow_wk_head   = 0;
    int unsigned       shadow_wk_tail   = 0;
    int unsigned       shadow_wk_fill   = 0;
    logic [PEND_W-1:0] shadow_pending   = '0;
    logic [WC_W-1:0]   shadow_workers   = '0;

    t_result dispatch_expected [$];   // predicted results, oldest first

    int n_errors   = 0;
    int n_checked  = 0;
    int n_commands = 0;
    int status_seen [4];

    // stimulus pacing knobs, set by the test tasks while idle
    bit tx_bursty       = 1'b0;
    int tx_burst_left   = 0;
    bit rx_stall_on     = 1'b0;
    int rx_hold_request = 0;

    initial begin
        for (int l = 0; l < NUM_PRIO; l++) begin
            shadow_prio_head[l] = 0;
            shadow_prio_tail[l] = 0;
            shadow_prio_fill[l] = 0;
        end
        for (int s = 0; s < 4; s++) status_seen[s] = 0;
    end

    // One command step of the dispatcher: updates the shadow state and
    // returns the result transaction it produces.
    function automatic t_result predict_dispatch(t_cmd c, logic [TAG_W-1:0] tag,
                                                 logic [PRIO_W-1:0] prio, logic hv);
        t_result     r;
        int unsigned lvl;
        logic [8:0]  entry;
        bit          got;
        r.found  = 1'b0;
        r.tag    = '0;
        r.route  = ROUTE_NONE;
        r.status = ST_OK;
        entry    = '0;
        got      = 1'b0;
        case (c)
            CMD_ADD: begin
                // priorities past the last level fold onto the lowest one
                lvl = (prio > NUM_PRIO - 1) ? NUM_PRIO - 1 : prio;
                if (shadow_prio_fill[lvl] >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_prio_mem[lvl][shadow_prio_tail[lvl]] = {hv, tag};
                    shadow_prio_tail[lvl] = (shadow_prio_tail[lvl] + 1) % QUEUE_DEPTH;
                    shadow_prio_fill[lvl]++;
                    if (shadow_pending == PEND_MAX) r.status = ST_SAT;
                    else shadow_pending++;
                end
            end
            CMD_SCHED: begin
                for (lvl = 0; lvl < NUM_PRIO; lvl++) begin
                    if (!got && shadow_prio_fill[lvl] != 0) begin
                        entry = shadow_prio_mem[lvl][shadow_prio_head[lvl]];
                        shadow_prio_head[lvl] = (shadow_prio_head[lvl] + 1) % QUEUE_DEPTH;
                        shadow_prio_fill[lvl]--;
                        got = 1'b1;
                    end
                end
                if (!got) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.found = 1'b1;
                    r.tag   = entry[7:0];
                    if (!entry[8] || shadow_workers == 0) begin
                        r.route = ROUTE_LOCAL;
                    end else if (shadow_wk_fill < WORKER_DEPTH) begin
                        shadow_wk_mem[shadow_wk_tail] = entry[7:0];
                        shadow_wk_tail = (shadow_wk_tail + 1) % WORKER_DEPTH;
                        shadow_wk_fill++;
                        r.route = ROUTE_WORKER;
                    end else begin
                        // heavy task lost: worker queue full
                        r.status = ST_FULL;
                    end
                end
            end
            CMD_FETCH: begin
                if (shadow_wk_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.found = 1'b1;
                    r.tag   = shadow_wk_mem[shadow_wk_head];
                    shadow_wk_head = (shadow_wk_head + 1) % WORKER_DEPTH;
                    shadow_wk_fill--;
                end
            end
            default: begin
                if (shadow_pending == 0) r.status = ST_SAT;
                else shadow_pending--;
            end
        endcase
        r.busy = (shadow_pending != 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result transaction against the oldest
    // prediction, then predicts each accepted command transaction. A result
    // is registered only after its command has been accepted, so order here is safe.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (dispatch_expected.size() == 0) begin
                    n_errors++;
                    $display("%0t: result transaction with nothing expected, actual tag %0h",
                             $time, o_out_tag);
                end else begin
                    want = dispatch_expected.pop_front();
                    check_field("found",    32'(want.found),  32'(o_found));
                    check_field("out_tag",  32'(want.tag),    32'(o_out_tag));
                    check_field("route",    32'(want.route),  32'(o_route));
                    check_field("status",   32'(want.status), 32'(o_status));
                    check_field("busy_res", 32'(want.busy),   32'(o_busy_res));
                    status_seen[want.status]++;
                    n_checked++;
                end
            end
            if (i_valid && o_ready) begin
                dispatch_expected.push_back(predict_dispatch(t_cmd'(i_cmd), i_task_tag,
                                                             i_priority_req, i_heavy));
                n_commands++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result-side ready: always ready, a random on/off pattern, or a long
    // hold-off counted here once a test asks for one.
    // ------------------------------------------------------------------------
    int rx_hold_left = 0;
    int rx_run_left  = 0;

    always @(posedge i_clk) begin
        if (rx_hold_request != 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left != 0) begin
            i_ready <= 1'b0;
            rx_hold_left--;
        end else if (!rx_stall_on) begin
            i_ready <= 1'b1;
        end else if (rx_run_left != 0) begin
            rx_run_left--;
        end else begin
            // flip; stalls run shorter than ready stretches
            i_ready     <= !i_ready;
            rx_run_left  = i_ready ? $urandom_range(0, 5) : $urandom_range(0, 9);
        end
    end

    // ------------------------------------------------------------------------
    // Command sender. Valid stays high across back-to-back transactions and
    // only drops for a burst gap or a drain.
    // ------------------------------------------------------------------------
    task automatic send_cmd(input t_cmd c, input logic [TAG_W-1:0] tag,
                            input logic [PRIO_W-1:0] prio, input logic hv);
        int gap;
        if (tx_bursty) begin
            if (tx_burst_left == 0) begin
                gap = $urandom_range(1, 8);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                tx_burst_left = $urandom_range(1, 16);
            end
            tx_burst_left--;
        end
        i_valid        <= 1'b1;
        i_cmd          <= c;
        i_task_tag     <= tag;
        i_priority_req <= prio;
        i_heavy        <= hv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // command with random tag, priority and weight; half the priorities fall
    // on existing levels, the rest across the whole field
    task automatic send_op(input t_cmd c);
        logic [PRIO_W-1:0] prio;
        prio = PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, NUM_PRIO - 1)
                                            : $urandom_range(0, 15));
        send_cmd(c, TAG_W'($urandom_range(0, 255)), prio, 1'($urandom_range(0, 1)));
    endtask

    // stop offering and wait for every predicted result to come back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (dispatch_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input bit wr, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_WORKER_COUNT;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write worker_count (junk in the unused upper bits) and read it back
    task automatic set_worker_count(input logic [WC_W-1:0] value);
        logic [31:0] wdata;
        logic [31:0] rdata;
        drain_results();
        wdata       = $urandom;
        wdata[7:0]  = value;
        apb_transfer(1'b1, wdata, rdata);
        shadow_workers = value;
        apb_transfer(1'b0, '0, rdata);
        check_field("worker_count readback", {24'h0, shadow_workers}, rdata);
    endtask

    // schedule every queued task, then fetch every worker entry
    task automatic empty_all_queues();
        int n;
        drain_results();
        n = 0;
        for (int l = 0; l < NUM_PRIO; l++) n += shadow_prio_fill[l];
        repeat (n) send_op(CMD_SCHED);
        drain_results();
        n = shadow_wk_fill;
        repeat (n) send_op(CMD_FETCH);
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_state();
        logic [31:0] rdata;
        apb_transfer(1'b0, '0, rdata);
        check_field("worker_count after reset", 32'h0, rdata);
        send_op(CMD_DONE);      // complete with nothing pending
        send_op(CMD_SCHED);     // schedule with all queues empty
        send_op(CMD_FETCH);     // fetch from empty worker queue
        drain_results();
    endtask

    task automatic test_routing();
        // no workers: heavy task still runs locally
        send_cmd(CMD_ADD, 8'hFF, 4'd0, 1'b1);
        send_cmd(CMD_SCHED, 8'h00, 4'd0, 1'b0);
        set_worker_count(8'hFF);
        send_cmd(CMD_ADD, 8'h00, 4'd15, 1'b1);   // priority clamps to lowest
        send_cmd(CMD_ADD, 8'hA5, 4'd1, 1'b0);
        send_cmd(CMD_ADD, 8'h5A, 4'd2, 1'b1);
        send_cmd(CMD_ADD, 8'h3C, 4'd0, 1'b1);
        repeat (4) send_op(CMD_SCHED);           // strict priority order
        repeat (4) send_op(CMD_FETCH);           // last one finds it empty
        repeat (6) send_op(CMD_DONE);            // down to zero, then one extra
        drain_results();
    endtask

    task automatic test_random_phase(input logic [WC_W-1:0] workers, input bit bursty,
                                     input bit stalls, input int n_items);
        int bias;
        int pick;
        set_worker_count(workers);
        tx_bursty   = bursty;
        rx_stall_on = stalls;
        bias        = 1;
        for (int i = 0; i < n_items; i++) begin
            // every 32 commands lean toward filling, balance or draining
            if (i % 32 == 0) bias = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            case (bias)
                0:       pick = (pick < 60) ? 0 : (pick < 80) ? 1 : (pick < 90) ? 2 : 3;
                1:       pick = (pick < 30) ? 0 : (pick < 60) ? 1 : (pick < 80) ? 2 : 3;
                default: pick = (pick < 15) ? 0 : (pick < 60) ? 1 : (pick < 85) ? 2 : 3;
            endcase
            send_op(t_cmd'(pick));
        end
        drain_results();
        tx_bursty   = 1'b0;
        rx_stall_on = 1'b0;
    endtask

    // overflow one priority queue, then the worker queue
    task automatic test_fifo_overflow();
        int unsigned       lvl;
        logic [PRIO_W-1:0] prio;
        set_worker_count(8'd1);
        empty_all_queues();
        lvl  = $urandom_range(0, NUM_PRIO - 1);
        prio = PRIO_W'(lvl);
        repeat (QUEUE_DEPTH + 1) begin
            if (lvl == NUM_PRIO - 1) prio = PRIO_W'($urandom_range(NUM_PRIO - 1, 15));
            send_cmd(CMD_ADD, TAG_W'($urandom_range(0, 255)), prio, 1'b1);
        end
        repeat (WORKER_DEPTH) send_op(CMD_SCHED);
        send_cmd(CMD_ADD, TAG_W'($urandom_range(0, 255)), prio, 1'b1);
        repeat (2) send_op(CMD_SCHED);           // dropped at worker queue, then empty
        repeat (WORKER_DEPTH + 1) send_op(CMD_FETCH);
        drain_results();
    endtask

    // long result hold-off while commands keep coming: input must stall
    task automatic test_backpressure();
        set_worker_count(WC_W'($urandom_range(2, 254)));
        rx_hold_request = 300;
        repeat (60) send_op(t_cmd'($urandom_range(0, 3)));
        drain_results();
    endtask

    // pending count stepped up and back down; the 16-bit ceiling needs far
    // more transactions than this run carries
    task automatic test_pending_count();
        set_worker_count(8'd0);
        empty_all_queues();
        repeat (3) send_op(CMD_ADD);
        repeat (3) send_op(CMD_SCHED);
        repeat (4) send_op(CMD_DONE);
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_routing();
        test_random_phase(8'd0,   1'b1, 1'b1, 300);
        test_random_phase(8'hFF,  1'b0, 1'b0, 400);
        test_fifo_overflow();
        test_random_phase(8'd1,   1'b1, 1'b0, 300);
        test_backpressure();
        test_random_phase(WC_W'($urandom_range(2, 254)), 1'b0, 1'b1, 400);
        test_random_phase(WC_W'($urandom_range(0, 255)), 1'b1, 1'b1, 400);
        test_pending_count();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (dispatch_expected.size() != 0) begin
            n_errors++;
            $display("%0t: %0d results never arrived", $time, dispatch_expected.size());
        end

        $display("Checked %0d results for %0d commands, %0d mismatches", n_checked,
                 n_commands, n_errors);
        $display("Status mix ok/full/empty/saturated: %0d/%0d/%0d/%0d, worker counts 0..255",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_SAT]);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/spdt_pkg.sv
rtl/spdt_ram.sv
rtl/spdt_ctrl.sv
rtl/strict_priority_task_dispatcher.sv
dv/testbench.sv
